@@ sv/bsdl_pkg.sv @@
// bsdl_pkg: shared types and constants for the bounded sorted deque list
// list depth, field widths, operation and status codes, command and status structs
// no dependencies
`timescale 1ns / 1ps

package bsdl_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int WORD_W     = 32;
   localparam int POS_W      = 5;
   localparam int MODE_W     = 3;
   localparam int STAT_W     = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT  = 3'd0,
      MODE_INS_BACK   = 3'd1,
      MODE_INS_SORTED = 3'd2,
      MODE_DEL_FRONT  = 3'd3,
      MODE_DEL_BACK   = 3'd4,
      MODE_DEL_VALUE  = 3'd5,
      MODE_DUMP_FWD   = 3'd6,
      MODE_DUMP_REV   = 3'd7
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic exec;       // carry out the accepted item, load its status result
      logic dump_load;  // set up the dump walk for the accepted item
      logic dump_emit;  // emit the entry under the walk index
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic list_empty;
      logic out_free;   // output register can take a result this cycle
      logic dump_final; // walk index is on the final entry
   } stat_type;

endpackage

@@ sv/bsdl_ctrl.sv @@
// bsdl_ctrl: controller state machine of the bounded sorted deque list
// sequences list operations and dump walks; uses bsdl_pkg
`timescale 1ns / 1ps

module bsdl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  bsdl_pkg::mode_type       req_mode,
   input  bsdl_pkg::stat_type       stat,
   output bsdl_pkg::cmd_type        cmd,
   output bsdl_pkg::state_type      state
);
   import bsdl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      is_dump;

   assign state   = state_ff;
   assign is_dump = (req_mode == MODE_DUMP_FWD) || (req_mode == MODE_DUMP_REV);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.exec       = 1'b0;
      cmd.dump_load  = 1'b0;
      cmd.dump_emit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               if (is_dump && !stat.list_empty) begin
                  cmd.dump_load = 1'b1;
                  state_in      = S_DUMP;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.dump_emit = 1'b1;
               if (stat.dump_final) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/bsdl_datapath.sv @@
// bsdl_datapath: shifting cell array, entry count, dump walk and output register
// parallel compare and shift for inserts and deletes; uses bsdl_pkg
`timescale 1ns / 1ps

module bsdl_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bsdl_pkg::cmd_type                    cmd,
   output bsdl_pkg::stat_type                   stat,
   input  bsdl_pkg::mode_type                   req_mode,
   input  logic signed [bsdl_pkg::WORD_W-1:0]   req_value,
   input  logic                                 rsp_tready,
   output logic                                 rsp_valid,
   output logic signed [bsdl_pkg::WORD_W-1:0]   rsp_data_word,
   output logic        [bsdl_pkg::POS_W-1:0]    rsp_position,
   output bsdl_pkg::status_type                 rsp_status,
   output logic                                 rsp_last
);
   import bsdl_pkg::*;

   logic signed [WORD_W-1:0] cells_ff [LIST_DEPTH];
   logic signed [WORD_W-1:0] cells_in [LIST_DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in, count_m1;
   logic [IDX_W-1:0]         walk_ff, walk_in;
   logic                     walk_rev_ff, walk_rev_in;

   logic                     out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] out_data_ff, out_data_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   status_type               out_status_ff, out_status_in;
   logic                     out_last_ff, out_last_in;

   logic [LIST_DEPTH-1:0]    cell_used, cell_ge, cell_eq;
   logic [IDX_W-1:0]         sort_idx, match_idx, op_idx;
   logic                     list_full, list_empty, match_found;
   logic                     ins_do, del_do;
   status_type               exec_status;
   logic [IDX_W:0]           walk_pos;

   assign count_m1   = count_ff - CNT_W'(1);
   assign list_full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign list_empty = (count_ff == '0);
   assign walk_pos   = {1'b0, walk_ff} + (IDX_W+1)'(1);

   assign stat.list_empty = list_empty;
   assign stat.out_free   = !out_valid_ff || rsp_tready;
   assign stat.dump_final = walk_rev_ff ? (walk_ff == '0) : (walk_ff == count_m1[IDX_W-1:0]);

   // parallel compare of every used cell against the item's value
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cell_used[i] = (CNT_W'(i) < count_ff);
         cell_ge[i]   = cell_used[i] && !(cells_ff[i] < req_value);
         cell_eq[i]   = cell_used[i] && (cells_ff[i] == req_value);
      end
   end

   // first-match encoders, front has priority
   always_comb begin
      sort_idx  = count_ff[IDX_W-1:0];
      match_idx = '0;
      for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
         if (cell_ge[i]) begin
            sort_idx = IDX_W'(i);
         end
         if (cell_eq[i]) begin
            match_idx = IDX_W'(i);
         end
      end
      match_found = |cell_eq;
   end

   // decode the operation
   always_comb begin
      ins_do      = 1'b0;
      del_do      = 1'b0;
      op_idx      = '0;
      exec_status = ST_OK;
      case (req_mode)
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_SORTED: begin
            if (list_full) begin
               exec_status = ST_FULL;
            end else begin
               ins_do = 1'b1;
               if (req_mode == MODE_INS_BACK) begin
                  op_idx = count_ff[IDX_W-1:0];
               end else if (req_mode == MODE_INS_SORTED) begin
                  op_idx = sort_idx;
               end
            end
         end
         MODE_DEL_FRONT, MODE_DEL_BACK: begin
            if (list_empty) begin
               exec_status = ST_EMPTY;
            end else begin
               del_do = 1'b1;
               if (req_mode == MODE_DEL_BACK) begin
                  op_idx = count_m1[IDX_W-1:0];
               end
            end
         end
         MODE_DEL_VALUE: begin
            if (list_empty) begin
               exec_status = ST_EMPTY;
            end else if (match_found) begin
               del_do = 1'b1;
               op_idx = match_idx;
            end else begin
               exec_status = ST_NOTFOUND;
            end
         end
         default: begin
            // a dump only reaches here on an empty list
            exec_status = ST_EMPTY;
         end
      endcase
   end

   // cell shift network and count update
   always_comb begin
      int prv;
      int nxt;
      prv      = 0;
      nxt      = 0;
      count_in = count_ff;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (cmd.exec && ins_do) begin
         count_in = count_ff + CNT_W'(1);
         for (int i = 0; i < LIST_DEPTH; i++) begin
            prv = (i == 0) ? 0 : i - 1;
            if (IDX_W'(i) == op_idx) begin
               cells_in[i] = req_value;
            end else if (IDX_W'(i) > op_idx) begin
               cells_in[i] = cells_ff[prv];
            end
         end
      end else if (cmd.exec && del_do) begin
         count_in = count_m1;
         for (int i = 0; i < LIST_DEPTH; i++) begin
            nxt = (i == LIST_DEPTH - 1) ? i : i + 1;
            if (IDX_W'(i) >= op_idx) begin
               cells_in[i] = cells_ff[nxt];
            end
         end
      end
   end

   // dump walk and output register
   always_comb begin
      walk_in       = walk_ff;
      walk_rev_in   = walk_rev_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_pos_in    = out_pos_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (cmd.dump_load) begin
         walk_rev_in = (req_mode == MODE_DUMP_REV);
         walk_in     = (req_mode == MODE_DUMP_REV) ? count_m1[IDX_W-1:0] : '0;
      end
      if (cmd.exec) begin
         out_valid_in  = 1'b1;
         out_data_in   = '0;
         out_pos_in    = '0;
         out_status_in = exec_status;
         out_last_in   = 1'b1;
      end
      if (cmd.dump_emit) begin
         out_valid_in  = 1'b1;
         out_data_in   = cells_ff[walk_ff];
         out_pos_in    = POS_W'(walk_pos);
         out_status_in = ST_OK;
         out_last_in   = stat.dump_final;
         walk_in       = walk_rev_ff ? walk_ff - IDX_W'(1) : walk_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      walk_ff       <= walk_in;
      walk_rev_ff   <= walk_rev_in;
      out_data_ff   <= out_data_in;
      out_pos_ff    <= out_pos_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_data_word = out_data_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ sv/bounded_sorted_deque_list.sv @@
// bounded_sorted_deque_list: top level of the bounded sorted deque list
// joins bsdl_ctrl and bsdl_datapath; uses bsdl_pkg
`timescale 1ns / 1ps
//
// usage
//   req channel: one item per operation, mode in req_tuser, signed word in req_tdata
//   rsp channel: result items, data word and position in rsp_tdata, status in
//   rsp_tuser, rsp_tlast marks the final result of an item
//   inserts and deletes: one status item, valid the cycle after acceptance; every
//   cell compares and shifts in parallel, so one such item per cycle unless stalled
//   dump of n entries: n result items, the first once the walk is set up and the
//   entry passes the single output register, then one per cycle unless stalled;
//   no item is taken meanwhile, so a dump holds the request side through its walk
//   dump of an empty list: a single empty status item, like any other operation
//   reset clears the entry count and the output register at once; no clearing pass,
//   cells are only read below the count
//   receiver stall: the result waits in the output register; req_tready drops until
//   it is taken, and a dump walk pauses on the entry it is showing
//
module bounded_sorted_deque_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [7:0]  req_tuser,   // mode[2:0], zeros above
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data_word[31:0], position[36:32], zeros above
   output logic [7:0]  rsp_tuser,   // status[1:0], zeros above
   output logic        rsp_tlast    // last_result
);
   import bsdl_pkg::*;

   cmd_type                  cmd;
   stat_type                 stat;
   state_type                state;
   mode_type                 req_mode;
   logic signed [WORD_W-1:0] req_value;
   logic signed [WORD_W-1:0] rsp_data_word;
   logic [POS_W-1:0]         rsp_position;
   status_type               rsp_status;

   // unpack the request item
   assign req_mode  = mode_type'(req_tuser[MODE_W-1:0]);
   assign req_value = req_tdata;

   bsdl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_mode),
      .stat       (stat),
      .cmd        (cmd),
      .state      (state)
   );

   bsdl_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_data_word (rsp_data_word),
      .rsp_position  (rsp_position),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_tlast)
   );

   // pack the result item
   assign rsp_tdata = {3'b000, rsp_position, rsp_data_word};
   assign rsp_tuser = {6'b000000, rsp_status};

   // a list operation gives its single closing result in the next cycle
   a_op_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_mode != MODE_DUMP_FWD && req_mode != MODE_DUMP_REV)
      |=> (rsp_tvalid && rsp_tlast))
      else $error("list operation did not give its result next cycle");

   // no item is taken while a dump walk is running
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      (state == S_DUMP) |-> !req_tready)
      else $error("item accepted during a dump walk");

   // a result that is not the final one only comes from a running dump
   a_non_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (state == S_DUMP))
      else $error("non-final result outside a dump walk");

   // a dump load only happens on a non-empty list, and the walk then starts
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_load |-> (!stat.list_empty ##1 state == S_DUMP))
      else $error("dump walk did not start correctly");

endmodule

@@ tb/sv/bounded_sorted_deque_list_tb.sv @@
// bounded_sorted_deque_list_tb: self-checking bench for the bounded sorted deque list
// a directed table, then phases of random items biased to fill and drain the list
// needs bsdl_pkg and bounded_sorted_deque_list
`timescale 1ns / 1ps

module bounded_sorted_deque_list_tb;
   import bsdl_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int TAIL_CYCLES  = 40;

   // one result item as the block should present it
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos;
      status_type        status;
      logic              last;
   } list_result_type;

   // a status typed into the directed table overrides the shadow list's answer
   typedef struct packed {
      logic       pinned;
      status_type status;
   } pinned_status_type;

   typedef struct packed {
      mode_type          op;
      logic [WORD_W-1:0] word;
      logic [7:0]        reps;    // repeats of the row, word counts up by one each time
      logic              pinned;
      status_type        status;
   } directed_row_type;

   localparam int NUM_ROWS = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value[31:0]
   logic [7:0]  req_tuser = '0;   // mode[2:0], zeros above
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // data_word[31:0], position[36:32], zeros above
   logic [7:0]  rsp_tuser;        // status[1:0], zeros above
   logic        rsp_tlast;        // last_result

   // shadow copy of the list, front entry in slot 0
   logic [WORD_W-1:0] shadow_words [LIST_DEPTH];
   int                shadow_len = 0;

   list_result_type   pending_results [$];
   pinned_status_type pinned_status_q [$];
   int                error_count = 0;
   int                burst_left = 0;
   int                stall_left = 0;
   int                rx_cycle = 0;

   // directed table: empty-list cases, single-entry deletes, extremes, equal heads,
   // a forward dump, a fill to full, the full rejections and a reverse dump when full
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{MODE_DUMP_FWD,   32'h0000_0000, 8'd1, 1'b1, ST_EMPTY},
      '{MODE_DUMP_REV,   32'h0000_0000, 8'd1, 1'b1, ST_EMPTY},
      '{MODE_DEL_FRONT,  32'h0000_0000, 8'd1, 1'b1, ST_EMPTY},
      '{MODE_DEL_BACK,   32'hFFFF_FFFF, 8'd1, 1'b1, ST_EMPTY},
      '{MODE_DEL_VALUE,  32'h0000_0000, 8'd1, 1'b1, ST_EMPTY},
      '{MODE_INS_FRONT,  32'h7FFF_FFFF, 8'd1, 1'b1, ST_OK},
      '{MODE_DEL_VALUE,  32'h7FFF_FFFF, 8'd1, 1'b1, ST_OK},
      '{MODE_INS_BACK,   32'h8000_0000, 8'd1, 1'b1, ST_OK},
      '{MODE_DEL_BACK,   32'h0000_0000, 8'd1, 1'b1, ST_OK},
      '{MODE_INS_SORTED, 32'h0000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_SORTED, 32'h0000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_SORTED, 32'h8000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_SORTED, 32'h7FFF_FFFF, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_SORTED, 32'hFFFF_FFFF, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_FRONT,  32'h0000_0010, 8'd1, 1'b0, ST_OK},
      '{MODE_INS_BACK,   32'hFFFF_FFF0, 8'd1, 1'b0, ST_OK},
      '{MODE_DUMP_FWD,   32'h0000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_DEL_VALUE,  32'h1234_5678, 8'd1, 1'b1, ST_NOTFOUND},
      '{MODE_INS_BACK,   32'hA5A5_0000, 8'd9, 1'b0, ST_OK},
      '{MODE_INS_FRONT,  32'h0000_0001, 8'd1, 1'b1, ST_FULL},
      '{MODE_INS_BACK,   32'h0000_0001, 8'd1, 1'b1, ST_FULL},
      '{MODE_INS_SORTED, 32'h0000_0001, 8'd1, 1'b1, ST_FULL},
      '{MODE_DUMP_REV,   32'h0000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_DEL_FRONT,  32'h0000_0000, 8'd1, 1'b0, ST_OK},
      '{MODE_DEL_VALUE,  32'h0000_0000, 8'd1, 1'b0, ST_OK}
   };

   bounded_sorted_deque_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow list

   function automatic void shadow_insert(int slot, logic [WORD_W-1:0] word);
      for (int k = shadow_len; k > slot; k--) shadow_words[k] = shadow_words[k-1];
      shadow_words[slot] = word;
      shadow_len++;
   endfunction

   function automatic void shadow_remove(int slot);
      for (int k = slot; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
      shadow_len--;
   endfunction

   function automatic void expect_result(logic [WORD_W-1:0] word, int pos, status_type st,
                                         logic last);
      list_result_type r;
      r.word   = word;
      r.pos    = POS_W'(pos);
      r.status = st;
      r.last   = last;
      pending_results.push_back(r);
   endfunction

   // carry one item out on the shadow list and queue the results it should cause
   function automatic void apply_list_op(mode_type op, logic [WORD_W-1:0] word);
      status_type st;
      int         slot;
      st = ST_OK;
      case (op)
         MODE_DUMP_FWD, MODE_DUMP_REV: begin
            if (shadow_len == 0) begin
               expect_result('0, 0, ST_EMPTY, 1'b1);
            end else begin
               // backward dumps keep front-based positions, so they count down
               for (int k = 0; k < shadow_len; k++) begin
                  slot = (op == MODE_DUMP_FWD) ? k : shadow_len - 1 - k;
                  expect_result(shadow_words[slot], slot + 1, ST_OK, k == shadow_len - 1);
               end
            end
            return;
         end
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_SORTED: begin
            if (shadow_len >= LIST_DEPTH) begin
               st = ST_FULL;
            end else if (op == MODE_INS_FRONT) begin
               shadow_insert(0, word);
            end else if (op == MODE_INS_BACK) begin
               shadow_insert(shadow_len, word);
            end else begin
               // goes ahead of the first entry not less than it, equal ones included
               slot = 0;
               while (slot < shadow_len && $signed(shadow_words[slot]) < $signed(word))
                  slot++;
               shadow_insert(slot, word);
            end
         end
         MODE_DEL_FRONT, MODE_DEL_BACK: begin
            if (shadow_len == 0) st = ST_EMPTY;
            else if (op == MODE_DEL_FRONT) shadow_remove(0);
            else shadow_remove(shadow_len - 1);
         end
         default: begin
            if (shadow_len == 0) begin
               st = ST_EMPTY;
            end else begin
               slot = 0;
               while (slot < shadow_len && shadow_words[slot] != word) slot++;
               if (slot < shadow_len) shadow_remove(slot);
               else st = ST_NOTFOUND;
            end
         end
      endcase
      expect_result('0, 0, st, 1'b1);
   endfunction

   // ---------------------------------------------------------------- monitor

   // both channels are sampled at the edge, before any of this edge's updates land
   always @(posedge clock) begin
      int                depth_before;
      pinned_status_type pin;
      list_result_type   want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pin = '0;
            if (pinned_status_q.size() != 0) pin = pinned_status_q.pop_front();
            depth_before = pending_results.size();
            apply_list_op(mode_type'(req_tuser[MODE_W-1:0]), req_tdata);
            if (pin.pinned) begin
               while (pending_results.size() > depth_before) void'(pending_results.pop_back());
               expect_result('0, 0, pin.status, 1'b1);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item: data_word %h position %0d status %0d",
                      rsp_tdata[31:0], rsp_tdata[36:32], rsp_tuser[1:0]);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[31:0] !== want.word) begin
                  $error("data_word: expected %h, got %h", want.word, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[36:32] !== want.pos) begin
                  $error("position: expected %0d, got %0d", want.pos, rsp_tdata[36:32]);
                  error_count++;
               end
               if (rsp_tuser[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[1:0]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_result: expected %0d, got %0d", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // ready through the first quarter of each rx_cycle period, the rest broken by
   // random stalls, so stalls land on status items and on every step of a dump
   always @(posedge clock) begin
      logic ready_next;
      rx_cycle++;
      if ((rx_cycle % 256) < 64) begin
         ready_next = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         ready_next = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         ready_next = 1'b0;
         stall_left = $urandom_range(0, 19);
      end else begin
         ready_next = 1'b1;
      end
      rsp_tready <= ready_next;
   end

   // ---------------------------------------------------------------- sender

   // offer one item and hold it until taken; bursts end in a random gap
   task automatic send_item(mode_type op, logic [WORD_W-1:0] word, logic pinned,
                            status_type st);
      int gap;
      pinned_status_type pin;
      pin.pinned = pinned;
      pin.status = st;
      pinned_status_q.push_back(pin);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= {{(8-MODE_W){1'b0}}, op};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // often small words near zero and words already held, so sorted inserts meet
   // equal entries and deletes by value hit; the extremes now and then
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3, 4: return WORD_W'($urandom_range(0, 8)) - 32'd4;
         5, 6:    return (shadow_len > 0) ? shadow_words[$urandom_range(0, shadow_len - 1)]
                                          : WORD_W'($urandom);
         default: return WORD_W'($urandom);
      endcase
   endfunction

   initial begin
      int       roll;
      logic     filling;
      mode_type op;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         for (int k = 0; k < directed_rows[i].reps; k++)
            send_item(directed_rows[i].op, directed_rows[i].word + WORD_W'(k),
                      directed_rows[i].pinned, directed_rows[i].status);

      // random phases: a filling phase leans on inserts, a draining phase on deletes;
      // the shadow count only steers the phase, it may lag the block by one item
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (shadow_len >= LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
         if (shadow_len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         if ($urandom_range(0, 39) == 0) filling = !filling;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 70 : 20))
            op = mode_type'($urandom_range(MODE_INS_FRONT, MODE_INS_SORTED));
         else if (roll < (filling ? 92 : 90))
            op = mode_type'($urandom_range(MODE_DEL_FRONT, MODE_DEL_VALUE));
         else
            op = mode_type'($urandom_range(MODE_DUMP_FWD, MODE_DUMP_REV));
         send_item(op, pick_word(), 1'b0, ST_OK);
      end
      req_tvalid <= 1'b0;

      // let the last item's results queue, then drain and watch the tail
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("bounded_sorted_deque_list_tb: done, clean");
      end else begin
         $display("bounded_sorted_deque_list_tb: done, errors");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run: every item a full dump with
   // each result held by the longest stall
   initial begin
      #1_500_000;
      $display("bounded_sorted_deque_list_tb: done, errors");
      $finish;
   end

endmodule
